@@ design/hex8_pkg.sv @@
// ----------------------------------------------------------------------------
// hex8_pkg
// Shared types and constants for the 8-node hexahedron shape function unit.
// ----------------------------------------------------------------------------
package hex8_pkg;

    localparam int FRAC_BITS  = 14;
    localparam int NODE_COUNT = 8;
    localparam int AXES       = 3;
    localparam int IN_W       = 16;
    localparam int OUT_W      = 16;
    localparam int MODE_W     = 2;

    // coordinate after clamp: signed, holds +/-ONE
    localparam int COORD_W = FRAC_BITS + 2;
    // width used for the clamp compare (raw input or coordinate, whichever is wider)
    localparam int CMP_W   = (COORD_W > IN_W) ? COORD_W : IN_W;
    // factor (1 +/- x): unsigned, 0 .. 2*ONE
    localparam int FACT_W  = FRAC_BITS + 2;
    localparam int PAIR_W  = 2 * FACT_W;
    localparam int PROD_W  = 3 * FACT_W;
    // divide by 8 * ONE^2
    localparam int SHIFT   = 2 * FRAC_BITS + 3;
    localparam int MAG_W   = PROD_W - SHIFT;
    localparam int SAT_W   = (MAG_W > OUT_W + 1) ? MAG_W : OUT_W + 1;

    localparam logic signed [CMP_W-1:0] ONE_CMP  = CMP_W'(1) <<< FRAC_BITS;
    localparam logic signed [CMP_W-1:0] MONE_CMP = -ONE_CMP;
    localparam logic [FACT_W-1:0]       ONE_FACT = FACT_W'(1) << FRAC_BITS;
    localparam logic [PROD_W-1:0]       ROUND_BIAS = PROD_W'(1) << (SHIFT - 1);
    localparam logic [SAT_W-1:0]        SAT_POS  = SAT_W'((1 << (OUT_W - 1)) - 1);
    localparam logic [SAT_W-1:0]        SAT_NEG  = SAT_W'(1) << (OUT_W - 1);
    localparam logic [OUT_W-1:0]        OUT_MAX  = OUT_W'((1 << (OUT_W - 1)) - 1);
    localparam logic [OUT_W-1:0]        OUT_MIN  = OUT_W'(1) << (OUT_W - 1);

    typedef enum logic [MODE_W-1:0] {
        MODE_SHAPE = 2'd0,
        MODE_DCSI  = 2'd1,
        MODE_DETA  = 2'd2,
        MODE_DZETA = 2'd3
    } t_mode;

    // bit k set: corner sits at +1 along axis k (csi, eta, zeta)
    localparam logic [AXES-1:0] CORNER_POS [NODE_COUNT] = '{
        3'b000, 3'b001, 3'b011, 3'b010,
        3'b100, 3'b101, 3'b111, 3'b110
    };

endpackage

@@ design/hex8_shape_function_eval_unit.sv @@
// ----------------------------------------------------------------------------
// hex8_shape_function_eval_unit
// Trilinear 8-node hexahedron: shape values or partial derivatives at a point.
// ----------------------------------------------------------------------------
// Usage:
//   Drive i_mode, i_csi, i_eta, i_zeta and raise start. A beat is taken at
//   every rising edge with start high and busy low; busy is always low, so a
//   new point can be issued every cycle.
//   Coordinates are Q2.14 and clamped to [-1,1]. Mode 0 gives N_i, modes 1..3
//   give dN_i/dcsi, dN_i/deta, dN_i/dzeta. Results are rounded to nearest.
//   The eight node values appear on o_node*_value with o_valid high for one
//   cycle, from the output register. The steps, each registered: clamp (at
//   the accepting edge), factor select and first multiply, second multiply,
//   round and saturate. Throughput is one point per cycle.
//   The receiver cannot stall; each result is on the ports for one cycle only.
//   Synchronous reset clears the valid bits of all stages, dropping any point
//   in flight; data registers are not reset.
// ----------------------------------------------------------------------------
module hex8_shape_function_eval_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [hex8_pkg::MODE_W-1:0]         i_mode,
    input  logic signed [hex8_pkg::IN_W-1:0]    i_csi,
    input  logic signed [hex8_pkg::IN_W-1:0]    i_eta,
    input  logic signed [hex8_pkg::IN_W-1:0]    i_zeta,
    output logic                                o_valid,
    output logic signed [hex8_pkg::OUT_W-1:0]   o_node0_value,
    output logic signed [hex8_pkg::OUT_W-1:0]   o_node1_value,
    output logic signed [hex8_pkg::OUT_W-1:0]   o_node2_value,
    output logic signed [hex8_pkg::OUT_W-1:0]   o_node3_value,
    output logic signed [hex8_pkg::OUT_W-1:0]   o_node4_value,
    output logic signed [hex8_pkg::OUT_W-1:0]   o_node5_value,
    output logic signed [hex8_pkg::OUT_W-1:0]   o_node6_value,
    output logic signed [hex8_pkg::OUT_W-1:0]   o_node7_value
);

    localparam int NN = hex8_pkg::NODE_COUNT;
    localparam int NA = hex8_pkg::AXES;

    // stage 1: clamped coordinates
    logic                                       r_s1_valid, n_s1_valid;
    hex8_pkg::t_mode                            r_s1_mode, n_s1_mode;
    logic signed [hex8_pkg::COORD_W-1:0]        r_s1_x [NA];
    logic signed [hex8_pkg::COORD_W-1:0]        n_s1_x [NA];

    // stage 2: first two factors multiplied, third factor carried
    logic                                       r_s2_valid, n_s2_valid;
    logic [hex8_pkg::PAIR_W-1:0]                r_s2_ab  [NN];
    logic [hex8_pkg::PAIR_W-1:0]                n_s2_ab  [NN];
    logic [hex8_pkg::FACT_W-1:0]                r_s2_c   [NN];
    logic [hex8_pkg::FACT_W-1:0]                n_s2_c   [NN];
    logic [NN-1:0]                              r_s2_neg, n_s2_neg;

    // stage 3: full product
    logic                                       r_s3_valid, n_s3_valid;
    logic [hex8_pkg::PROD_W-1:0]                r_s3_prod [NN];
    logic [hex8_pkg::PROD_W-1:0]                n_s3_prod [NN];
    logic [NN-1:0]                              r_s3_neg, n_s3_neg;

    // stage 4: output register
    logic                                       r_out_valid, n_out_valid;
    logic [hex8_pkg::OUT_W-1:0]                 r_out [NN];
    logic [hex8_pkg::OUT_W-1:0]                 n_out [NN];

    logic                                       accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // ---- stage 1: clamp ----
    always_comb begin
        logic signed [hex8_pkg::CMP_W-1:0] raw [NA];
        raw[0] = hex8_pkg::CMP_W'(i_csi);
        raw[1] = hex8_pkg::CMP_W'(i_eta);
        raw[2] = hex8_pkg::CMP_W'(i_zeta);
        n_s1_valid = accept;
        n_s1_mode  = hex8_pkg::t_mode'(i_mode);
        for (int k = 0; k < NA; k++) begin
            if (raw[k] > hex8_pkg::ONE_CMP) begin
                n_s1_x[k] = hex8_pkg::COORD_W'(hex8_pkg::ONE_CMP);
            end else if (raw[k] < hex8_pkg::MONE_CMP) begin
                n_s1_x[k] = hex8_pkg::COORD_W'(hex8_pkg::MONE_CMP);
            end else begin
                n_s1_x[k] = hex8_pkg::COORD_W'(raw[k]);
            end
        end
    end

    // ---- stage 2: factor select, first multiply ----
    always_comb begin
        logic [hex8_pkg::FACT_W-1:0]         f_plus  [NA];
        logic [hex8_pkg::FACT_W-1:0]         f_minus [NA];
        logic [NA-1:0]                       derived;
        logic [hex8_pkg::FACT_W-1:0]         f [NA];
        logic signed [hex8_pkg::COORD_W:0]   wide_one;
        logic signed [hex8_pkg::COORD_W:0]   wide_x;
        logic signed [hex8_pkg::COORD_W:0]   tmp;
        logic                                neg;
        wide_one = (hex8_pkg::COORD_W + 1)'(hex8_pkg::ONE_FACT);
        derived[0] = (r_s1_mode == hex8_pkg::MODE_DCSI);
        derived[1] = (r_s1_mode == hex8_pkg::MODE_DETA);
        derived[2] = (r_s1_mode == hex8_pkg::MODE_DZETA);
        for (int k = 0; k < NA; k++) begin
            wide_x     = (hex8_pkg::COORD_W + 1)'(r_s1_x[k]);
            tmp        = wide_one + wide_x;
            f_plus[k]  = tmp[hex8_pkg::FACT_W-1:0];
            tmp        = wide_one - wide_x;
            f_minus[k] = tmp[hex8_pkg::FACT_W-1:0];
        end
        n_s2_valid = r_s1_valid;
        for (int n = 0; n < NN; n++) begin
            neg = 1'b0;
            for (int k = 0; k < NA; k++) begin
                if (derived[k]) begin
                    f[k] = hex8_pkg::ONE_FACT;
                    if (!hex8_pkg::CORNER_POS[n][k]) begin
                        neg = 1'b1;
                    end
                end else if (hex8_pkg::CORNER_POS[n][k]) begin
                    f[k] = f_plus[k];
                end else begin
                    f[k] = f_minus[k];
                end
            end
            n_s2_ab[n]  = hex8_pkg::PAIR_W'(f[0]) * hex8_pkg::PAIR_W'(f[1]);
            n_s2_c[n]   = f[2];
            n_s2_neg[n] = neg;
        end
    end

    // ---- stage 3: second multiply ----
    always_comb begin
        n_s3_valid = r_s2_valid;
        n_s3_neg   = r_s2_neg;
        for (int n = 0; n < NN; n++) begin
            n_s3_prod[n] = hex8_pkg::PROD_W'(r_s2_ab[n]) * hex8_pkg::PROD_W'(r_s2_c[n]);
        end
    end

    // ---- stage 4: round half away from zero (on magnitude), sign, saturate ----
    always_comb begin
        logic [hex8_pkg::PROD_W-1:0] rounded;
        logic [hex8_pkg::SAT_W-1:0]  mag;
        logic [hex8_pkg::SAT_W-1:0]  negmag;
        n_out_valid = r_s3_valid;
        for (int n = 0; n < NN; n++) begin
            rounded = r_s3_prod[n] + hex8_pkg::ROUND_BIAS;
            mag     = hex8_pkg::SAT_W'(rounded[hex8_pkg::SHIFT +: hex8_pkg::MAG_W]);
            negmag  = hex8_pkg::SAT_W'(0) - mag;
            if (r_s3_neg[n]) begin
                if (mag > hex8_pkg::SAT_NEG) begin
                    n_out[n] = hex8_pkg::OUT_MIN;
                end else begin
                    n_out[n] = negmag[hex8_pkg::OUT_W-1:0];
                end
            end else if (mag > hex8_pkg::SAT_POS) begin
                n_out[n] = hex8_pkg::OUT_MAX;
            end else begin
                n_out[n] = mag[hex8_pkg::OUT_W-1:0];
            end
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_s2_valid  <= n_s2_valid;
            r_s3_valid  <= n_s3_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_s1_mode <= n_s1_mode;
        r_s1_x    <= n_s1_x;
        r_s2_ab   <= n_s2_ab;
        r_s2_c    <= n_s2_c;
        r_s2_neg  <= n_s2_neg;
        r_s3_prod <= n_s3_prod;
        r_s3_neg  <= n_s3_neg;
        r_out     <= n_out;
    end

    assign o_valid       = r_out_valid;
    assign o_node0_value = r_out[0];
    assign o_node1_value = r_out[1];
    assign o_node2_value = r_out[2];
    assign o_node3_value = r_out[3];
    assign o_node4_value = r_out[4];
    assign o_node5_value = r_out[5];
    assign o_node6_value = r_out[6];
    assign o_node7_value = r_out[7];

    // ---- assertions ----
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, 4))
        else $error("result beat without a start four cycles earlier");

    a_shape_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(i_mode == hex8_pkg::MODE_SHAPE, 4)) |->
        (!o_node0_value[hex8_pkg::OUT_W-1] && !o_node3_value[hex8_pkg::OUT_W-1] &&
         !o_node5_value[hex8_pkg::OUT_W-1] && !o_node6_value[hex8_pkg::OUT_W-1]))
        else $error("negative shape function value");

    a_dcsi_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(i_mode == hex8_pkg::MODE_DCSI, 4)) |->
        (o_node1_value == -o_node0_value))
        else $error("csi derivative of nodes 0 and 1 not opposite");

    a_deta_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(i_mode == hex8_pkg::MODE_DETA, 4)) |->
        (!o_node2_value[hex8_pkg::OUT_W-1] && (o_node1_value == -o_node2_value)))
        else $error("eta derivative sign wrong");

endmodule

@@ tb/sv/tb_hex8_shape_function_eval_unit.sv @@
// ----------------------------------------------------------------------------
// tb_hex8_shape_function_eval_unit
// Checks the 8-node hexahedron shape function unit against a built-in model.
// A table of directed points (corners, center, clamping, rounding ties, every
// mode) is followed by random points with random gaps on the command side.
// Each result is compared node by node with the oldest queued expectation.
// ----------------------------------------------------------------------------
module tb_hex8_shape_function_eval_unit;

    import hex8_pkg::*;

    localparam int  NODES          = hex8_pkg::NODE_COUNT;
    localparam int  WIDTH          = hex8_pkg::OUT_W;
    localparam int  RND_SHIFT      = 2 * hex8_pkg::FRAC_BITS + 3;
    localparam int  PIPE_LATENCY   = 4;
    localparam int  RAND_POINTS    = 500;
    localparam int  BURST_TAIL     = 100;
    localparam int  WATCHDOG_LIMIT = 1000;
    localparam int  TABLE_ROWS     = 18;

    typedef logic [NODES-1:0][WIDTH-1:0] t_node_vec;

    typedef struct packed {
        t_mode       mode;
        logic [15:0] csi;
        logic [15:0] eta;
        logic [15:0] zeta;
        logic        known;
        t_node_vec   vals;
    } t_point_row;

    localparam t_node_vec NO_VALS = '0;

    // node vectors are written node7 first, node0 last
    localparam t_point_row POINT_TABLE [TABLE_ROWS] = '{
        {MODE_SHAPE, -16'sd16384, -16'sd16384, -16'sd16384, 1'b1,
            {{7{16'sd0}}, 16'sd16384}},
        {MODE_SHAPE, 16'sd0, 16'sd0, 16'sd0, 1'b1, {8{16'sd2048}}},
        {MODE_DCSI, 16'sd0, 16'sd0, 16'sd0, 1'b1,
            {-16'sd2048, 16'sd2048, 16'sd2048, -16'sd2048,
             -16'sd2048, 16'sd2048, 16'sd2048, -16'sd2048}},
        // out of range on every axis, clamps onto corner (1,-1,1)
        {MODE_SHAPE, 16'sd32767, -16'sd32768, 16'sd32767, 1'b1,
            {16'sd0, 16'sd0, 16'sd16384, {5{16'sd0}}}},
        {MODE_DETA, 16'sd16384, 16'sd16384, 16'sd16384, 1'b1,
            {16'sd0, 16'sd8192, -16'sd8192, {5{16'sd0}}}},
        {MODE_DZETA, -16'sd16384, -16'sd16384, -16'sd16384, 1'b1,
            {{3{16'sd0}}, 16'sd8192, {3{16'sd0}}, -16'sd8192}},
        {MODE_DCSI, -16'sd32768, 16'sd32767, -16'sd32768, 1'b1,
            {{4{16'sd0}}, -16'sd8192, 16'sd8192, {2{16'sd0}}}},
        // exact halves: ties go away from zero, both signs
        {MODE_SHAPE, 16'sd4, 16'sd0, 16'sd0, 1'b0, NO_VALS},
        {MODE_DCSI, 16'sd0, 16'sd4, 16'sd0, 1'b0, NO_VALS},
        {MODE_DZETA, 16'sd16383, -16'sd16383, 16'sd1, 1'b0, NO_VALS},
        {MODE_DETA, -16'sd1, 16'sd1, -16'sd1, 1'b0, NO_VALS},
        {MODE_SHAPE, 16'sd16384, 16'sd16385, -16'sd16385, 1'b0, NO_VALS},
        {MODE_DZETA, 16'sd100, -16'sd200, 16'sd300, 1'b0, NO_VALS},
        {MODE_SHAPE, 16'sd8192, -16'sd8192, 16'sd4096, 1'b0, NO_VALS},
        {MODE_DETA, 16'sd32767, 16'sd0, -16'sd32768, 1'b0, NO_VALS},
        {MODE_DCSI, 16'sd1, -16'sd1, 16'sd16383, 1'b0, NO_VALS},
        {MODE_SHAPE, -16'sd16383, 16'sd16383, -16'sd1, 1'b0, NO_VALS},
        {MODE_DZETA, 16'h5555, 16'hAAAA, 16'h8001, 1'b0, NO_VALS}
    };

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      start;
    logic                      busy;
    logic [MODE_W-1:0]         i_mode;
    logic signed [IN_W-1:0]    i_csi;
    logic signed [IN_W-1:0]    i_eta;
    logic signed [IN_W-1:0]    i_zeta;
    logic                      o_valid;
    logic signed [OUT_W-1:0]   o_node0_value;
    logic signed [OUT_W-1:0]   o_node1_value;
    logic signed [OUT_W-1:0]   o_node2_value;
    logic signed [OUT_W-1:0]   o_node3_value;
    logic signed [OUT_W-1:0]   o_node4_value;
    logic signed [OUT_W-1:0]   o_node5_value;
    logic signed [OUT_W-1:0]   o_node6_value;
    logic signed [OUT_W-1:0]   o_node7_value;

    t_node_vec node_values_q [$];
    int        mismatch_count;
    int        results_checked;
    int        directed_sent;
    int        random_sent;

    hex8_shape_function_eval_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_mode        (i_mode),
        .i_csi         (i_csi),
        .i_eta         (i_eta),
        .i_zeta        (i_zeta),
        .o_valid       (o_valid),
        .o_node0_value (o_node0_value),
        .o_node1_value (o_node1_value),
        .o_node2_value (o_node2_value),
        .o_node3_value (o_node3_value),
        .o_node4_value (o_node4_value),
        .o_node5_value (o_node5_value),
        .o_node6_value (o_node6_value),
        .o_node7_value (o_node7_value)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Trilinear shape values or their partials, rounded half away from zero.
    function automatic t_node_vec eval_hex8_nodes(t_mode mode, logic signed [15:0] csi,
                                                  logic signed [15:0] eta,
                                                  logic signed [15:0] zeta);
        longint    one;
        longint    x [3];
        longint    f;
        longint    v;
        logic      pos;
        logic      neg;
        logic [95:0] prod;
        t_node_vec res;
        one  = longint'(1) << hex8_pkg::FRAC_BITS;
        x[0] = csi;
        x[1] = eta;
        x[2] = zeta;
        for (int k = 0; k < 3; k++) begin
            if (x[k] > one) x[k] = one;
            if (x[k] < -one) x[k] = -one;
        end
        for (int n = 0; n < NODES; n++) begin
            prod = 96'd1;
            neg  = 1'b0;
            for (int k = 0; k < 3; k++) begin
                // corner position along axis k follows from the node index
                case (k)
                    0:       pos = n[0] ^ n[1];
                    1:       pos = n[1];
                    default: pos = n[2];
                endcase
                if (int'(mode) == k + 1) begin
                    f = one;
                    if (!pos) neg = ~neg;
                end else begin
                    f = pos ? one + x[k] : one - x[k];
                end
                prod = prod * 96'(f);
            end
            prod = (prod + (96'd1 << (RND_SHIFT - 1))) >> RND_SHIFT;
            if (prod > (96'd1 << 20)) prod = 96'd1 << 20;
            v = neg ? -longint'(prod) : longint'(prod);
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            res[n] = v[15:0];
        end
        return res;
    endfunction

    function automatic logic [15:0] pick_coord();
        case ($urandom_range(0, 9))
            0, 1:    return 16'($urandom);
            2: begin
                case ($urandom_range(0, 5))
                    0:       return 16'sd16384;
                    1:       return -16'sd16384;
                    2:       return 16'sd0;
                    3:       return 16'sd16383;
                    4:       return -16'sd16383;
                    default: return 16'($urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000);
                endcase
            end
            default: return 16'($urandom_range(0, 32768) - 16384);
        endcase
    endfunction

    // one beat on the command side; the expectation is queued on acceptance
    task automatic send_point(t_mode mode, logic [15:0] csi, logic [15:0] eta,
                              logic [15:0] zeta, logic known, t_node_vec given);
        i_mode <= mode;
        i_csi  <= csi;
        i_eta  <= eta;
        i_zeta <= zeta;
        start  <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        node_values_q.push_back(known ? given : eval_hex8_nodes(mode, csi, eta, zeta));
    endtask

    task automatic idle_cycles(int count);
        start  <= 1'b0;
        i_mode <= MODE_W'($urandom);
        i_csi  <= 16'($urandom);
        i_eta  <= 16'($urandom);
        i_zeta <= 16'($urandom);
        repeat (count) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (node_values_q.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : result_check
        t_node_vec got;
        t_node_vec want;
        int        stall_cycles;
        if (!i_rst_n) begin
            stall_cycles = 0;
        end else begin
            if (o_valid === 1'b1) begin
                got = {o_node7_value, o_node6_value, o_node5_value, o_node4_value,
                       o_node3_value, o_node2_value, o_node1_value, o_node0_value};
                if (node_values_q.size() == 0) begin
                    $display("%0t: result beat with nothing expected (node0 %0d)",
                             $time, $signed(got[0]));
                    mismatch_count++;
                end else begin
                    want = node_values_q.pop_front();
                    results_checked++;
                    for (int n = 0; n < NODES; n++) begin
                        if (got[n] !== want[n]) begin
                            $display("%0t: node%0d expected %0d, actual %0d", $time, n,
                                     $signed(want[n]), $signed(got[n]));
                            mismatch_count++;
                        end
                    end
                end
            end
            if (o_valid === 1'b1 || (start === 1'b1 && busy === 1'b0)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
                if (stall_cycles >= WATCHDOG_LIMIT) begin
                    $display("%0t: timeout, %0d results outstanding", $time,
                             node_values_q.size());
                    $display("Mismatches found");
                    $finish;
                end
            end
        end
    end

    initial begin : stimulus
        int quiet_left;
        mismatch_count  = 0;
        results_checked = 0;
        directed_sent   = 0;
        random_sent     = 0;
        quiet_left      = 0;
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_mode  <= MODE_SHAPE;
        i_csi   <= '0;
        i_eta   <= '0;
        i_zeta  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < TABLE_ROWS; r++) begin
            send_point(POINT_TABLE[r].mode, POINT_TABLE[r].csi, POINT_TABLE[r].eta,
                       POINT_TABLE[r].zeta, POINT_TABLE[r].known, POINT_TABLE[r].vals);
            directed_sent++;
        end
        wait_drained();

        for (int i = 0; i < RAND_POINTS; i++) begin
            if (i == RAND_POINTS / 2) wait_drained();
            // tail of the run streams back to back
            if (i < RAND_POINTS - BURST_TAIL) begin
                if (quiet_left > 0) quiet_left--;
                else if ($urandom_range(0, 15) == 0) quiet_left = $urandom_range(10, 30);
                else if ($urandom_range(0, 2) == 0) idle_cycles($urandom_range(1, 3));
            end
            send_point(t_mode'($urandom_range(0, 3)), pick_coord(), pick_coord(),
                       pick_coord(), 1'b0, NO_VALS);
            random_sent++;
        end

        wait_drained();
        repeat (PIPE_LATENCY + 4) @(posedge i_clk);
        $display("Sent %0d table points and %0d random points across all four modes,",
                 directed_sent, random_sent);
        $display("including clamped coordinates and rounding ties; %0d results compared.",
                 results_checked);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
